@@ rtl/msixw_pkg.sv @@
// msixw_pkg: types and constants shared by the msi-x capability walker
// holds the request/result payload structs and the walk phase encoding
// no dependencies
package msixw_pkg;

	localparam int unsigned HDR_CNT_W = 6;
	localparam logic [HDR_CNT_W-1:0] MAX_HEADERS = 6'd48;

	localparam logic       KIND_START   = 1'b0;
	localparam logic       KIND_DATA    = 1'b1;
	localparam logic       OUT_REQUEST  = 1'b0;
	localparam logic       OUT_RESULT   = 1'b1;

	localparam logic [7:0] CAP_ID_MSIX   = 8'h11;
	localparam logic [7:0] OFS_CMD_STAT  = 8'h04;
	localparam logic [7:0] OFS_CAP_PTR   = 8'h34;
	localparam logic [7:0] OFS_TABLE     = 8'h04;
	localparam logic [7:0] OFS_PBA       = 8'h08;
	localparam int unsigned CAP_LIST_BIT = 20;

	typedef struct packed {
		logic        kind;
		logic [7:0]  bus;
		logic [4:0]  slot;
		logic [2:0]  func;
		logic [31:0] read_data;
	} in_item_t;

	typedef struct packed {
		logic        out_kind;
		logic [23:0] config_address;
		logic        found;
		logic [7:0]  cap_ofs;
		logic [15:0] msg_ctrl;
		logic [11:0] tbl_len;
		logic [31:0] tbl_ofs;
		logic [2:0]  tbl_bar;
		logic [31:0] pba_ofs;
		logic [2:0]  pba_bar;
	} out_item_t;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_STATUS = 6'b000010,
		PH_PTR    = 6'b000100,
		PH_HEADER = 6'b001000,
		PH_TABLE  = 6'b010000,
		PH_PBA    = 6'b100000
	} phase_t;

endpackage

@@ rtl/msixw_in_if.sv @@
// msixw_in_if: valid/ready channel carrying walker input items
// depends on msixw_pkg for the payload struct
interface msixw_in_if;
	import msixw_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/msixw_out_if.sv @@
// msixw_out_if: valid/ready channel carrying walker requests and results
// depends on msixw_pkg for the payload struct
interface msixw_out_if;
	import msixw_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/msix_capability_walker.sv @@
// msix_capability_walker: walks a pci function's capability list for msi-x
// pipeline: two register stages, an accepted item is held in the input register and its output in the output register
// throughput: one item per cycle while result.ready holds, set by the single input and output register pair
// reset (arst_n low, asynchronous): walk phase idle, both stages empty, saved fields zero
// depends on msixw_pkg, msixw_in_if, msixw_out_if
module msix_capability_walker
	import msixw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	msixw_in_if.sink           walk,
	msixw_out_if.source        result
);

	// input stage
	logic     valid_s1;
	in_item_t item_s1;

	// walk state
	phase_t                 phase_q;
	logic [15:0]            target_function_q;
	logic [7:0]             current_offset_q;
	logic [HDR_CNT_W-1:0]   headers_seen_q;
	logic [15:0]            saved_control_q;
	logic [31:0]            saved_table_word_q;

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	// next-state and result of the item in stage 1
	phase_t               phase_d;
	logic [7:0]           current_offset_d;
	logic [HDR_CNT_W-1:0] headers_seen_d;
	logic [15:0]          saved_control_d;
	logic [31:0]          saved_table_word_d;
	logic [15:0]          target_function_d;
	logic                 res_valid;
	out_item_t            res;

	logic                 advance;
	logic [HDR_CNT_W-1:0] headers_inc;
	logic [7:0]           link_ptr;
	logic [7:0]           req_offset;
	logic                 emit_req;
	logic                 emit_done;
	logic                 done_found;

	// stage 1 moves on whenever the output register is free or being drained
	assign advance      = !out_valid_q || result.ready;
	assign walk.ready   = !valid_s1 || advance;
	assign result.valid = out_valid_q;
	assign result.payload = out_q;

	assign headers_inc = headers_seen_q + 1'b1;
	assign link_ptr    = item_s1.read_data[15:8];

	always_comb begin
		phase_d            = phase_q;
		current_offset_d   = current_offset_q;
		headers_seen_d     = headers_seen_q;
		saved_control_d    = saved_control_q;
		saved_table_word_d = saved_table_word_q;
		target_function_d  = target_function_q;
		emit_req           = 1'b0;
		emit_done          = 1'b0;
		done_found         = 1'b0;
		req_offset         = '0;

		if (item_s1.kind == KIND_START) begin
			// a start during a walk is dropped
			if (phase_q == PH_IDLE) begin
				target_function_d = {item_s1.bus, item_s1.slot, item_s1.func};
				headers_seen_d    = '0;
				phase_d           = PH_STATUS;
				emit_req          = 1'b1;
				req_offset        = OFS_CMD_STAT;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					// data with no walk running is dropped
				end
				PH_STATUS: begin
					// capability list bit of the status register
					if (!item_s1.read_data[CAP_LIST_BIT]) begin
						phase_d   = PH_IDLE;
						emit_done = 1'b1;
					end else begin
						phase_d    = PH_PTR;
						emit_req   = 1'b1;
						req_offset = OFS_CAP_PTR;
					end
				end
				PH_PTR: begin
					current_offset_d = item_s1.read_data[7:0];
					if (item_s1.read_data[7:0] == 8'h00) begin
						phase_d   = PH_IDLE;
						emit_done = 1'b1;
					end else begin
						headers_seen_d = '0;
						phase_d        = PH_HEADER;
						emit_req       = 1'b1;
						req_offset     = item_s1.read_data[7:0];
					end
				end
				PH_HEADER: begin
					headers_seen_d = headers_inc;
					priority if (item_s1.read_data[7:0] == CAP_ID_MSIX) begin
						saved_control_d = item_s1.read_data[31:16];
						phase_d         = PH_TABLE;
						emit_req        = 1'b1;
						req_offset      = current_offset_q + OFS_TABLE;
					end else if (link_ptr == 8'h00 || headers_inc >= MAX_HEADERS) begin
						// end of list or runaway list
						phase_d   = PH_IDLE;
						emit_done = 1'b1;
					end else begin
						current_offset_d = link_ptr;
						emit_req         = 1'b1;
						req_offset       = link_ptr;
					end
				end
				PH_TABLE: begin
					saved_table_word_d = item_s1.read_data;
					phase_d            = PH_PBA;
					emit_req           = 1'b1;
					req_offset         = current_offset_q + OFS_PBA;
				end
				PH_PBA: begin
					phase_d    = PH_IDLE;
					emit_done  = 1'b1;
					done_found = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// result assembly: request and not-found results carry zeros in unused fields
	always_comb begin
		res       = '0;
		res_valid = emit_req || emit_done;
		if (emit_req) begin
			res.out_kind       = OUT_REQUEST;
			res.config_address = {target_function_d, req_offset};
		end else if (emit_done) begin
			res.out_kind = OUT_RESULT;
			if (done_found) begin
				res.found    = 1'b1;
				res.cap_ofs  = current_offset_q;
				res.msg_ctrl = saved_control_q;
				res.tbl_len  = {1'b0, saved_control_q[10:0]} + 12'd1;
				res.tbl_ofs  = {saved_table_word_q[31:3], 3'b000};
				res.tbl_bar  = saved_table_word_q[2:0];
				res.pba_ofs  = {item_s1.read_data[31:3], 3'b000};
				res.pba_bar  = item_s1.read_data[2:0];
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (walk.ready) begin
			valid_s1 <= walk.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (walk.ready && walk.valid) begin
			item_s1 <= walk.payload;
		end
	end

	// walk state, updated as the stage 1 item retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q            <= PH_IDLE;
			target_function_q  <= '0;
			current_offset_q   <= '0;
			headers_seen_q     <= '0;
			saved_control_q    <= '0;
			saved_table_word_q <= '0;
		end else if (valid_s1 && advance) begin
			phase_q            <= phase_d;
			target_function_q  <= target_function_d;
			current_offset_q   <= current_offset_d;
			headers_seen_q     <= headers_seen_d;
			saved_control_q    <= saved_control_d;
			saved_table_word_q <= saved_table_word_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	// a request never carries discovery fields
	a_req_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.out_kind == OUT_REQUEST |-> !out_q.found && out_q.tbl_len == '0)
		else $error("request carries discovery fields");

	// a found result always reports at least one table entry
	a_found_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.found |-> out_q.tbl_len != '0 && out_q.out_kind == OUT_RESULT)
		else $error("found result with empty table");

	// a final result leaves the walker idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && emit_done |=> phase_q == PH_IDLE)
		else $error("walker not idle after final result");

	// header count never passes the limit
	a_hdr_limit: assert property (@(posedge clk) disable iff (!arst_n)
		headers_seen_q <= MAX_HEADERS)
		else $error("header count beyond limit");

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking bench for msix_capability_walker, mirrors the walk in a small tracker
// class, drives directed then random well-formed walks with noise and compares each output
// depends on msixw_pkg, msixw_in_if, msixw_out_if and the walker itself
module tb_top;
	import msixw_pkg::*;

	// walk mirror: follows the capability walk and queues the output each item should cause
	class walk_tracker;
		phase_t      phase        = PH_IDLE;
		logic [15:0] target_fn    = '0;
		logic [7:0]  cur_ofs      = '0;
		logic [5:0]  hdr_count    = '0;
		logic [15:0] saved_ctrl   = '0;
		logic [31:0] saved_tbl    = '0;
		out_item_t   awaited_outputs[$];
		int unsigned accepted     = 0;
		int unsigned produced     = 0;
		int unsigned errors       = 0;

		function void accept_item(in_item_t it);
			out_item_t o;
			bit        emit;
			bit        hit;
			logic [7:0] ofs;
			o    = '0;
			emit = 1'b1;
			hit  = 1'b0;
			ofs  = '0;
			accepted++;
			if (it.kind == KIND_START) begin
				// start while a walk is running is dropped
				if (phase != PH_IDLE) begin
					emit = 1'b0;
				end else begin
					target_fn = {it.bus, it.slot, it.func};
					hdr_count = '0;
					phase     = PH_STATUS;
					ofs       = OFS_CMD_STAT;
				end
			end else begin
				case (phase)
					PH_STATUS: begin
						if (!it.read_data[CAP_LIST_BIT]) begin
							phase = PH_IDLE;
							o.out_kind = OUT_RESULT;
						end else begin
							phase = PH_PTR;
							ofs   = OFS_CAP_PTR;
						end
					end
					PH_PTR: begin
						cur_ofs = it.read_data[7:0];
						if (cur_ofs == 8'h00) begin
							phase = PH_IDLE;
							o.out_kind = OUT_RESULT;
						end else begin
							hdr_count = '0;
							phase     = PH_HEADER;
							ofs       = cur_ofs;
						end
					end
					PH_HEADER: begin
						hdr_count = hdr_count + 6'd1;
						if (it.read_data[7:0] == CAP_ID_MSIX) begin
							saved_ctrl = it.read_data[31:16];
							phase      = PH_TABLE;
							ofs        = cur_ofs + OFS_TABLE;
						end else if (it.read_data[15:8] == 8'h00 || hdr_count >= MAX_HEADERS) begin
							phase = PH_IDLE;
							o.out_kind = OUT_RESULT;
						end else begin
							cur_ofs = it.read_data[15:8];
							ofs     = cur_ofs;
						end
					end
					PH_TABLE: begin
						saved_tbl = it.read_data;
						phase     = PH_PBA;
						ofs       = cur_ofs + OFS_PBA;
					end
					PH_PBA: begin
						phase = PH_IDLE;
						hit   = 1'b1;
						o.out_kind = OUT_RESULT;
					end
					default: begin
						// data while idle
						phase = PH_IDLE;
						emit  = 1'b0;
					end
				endcase
			end
			if (!emit)
				return;
			if (o.out_kind == OUT_REQUEST) begin
				o.config_address = {target_fn, ofs};
			end else if (hit) begin
				o.found    = 1'b1;
				o.cap_ofs  = cur_ofs;
				o.msg_ctrl = saved_ctrl;
				o.tbl_len  = {1'b0, saved_ctrl[10:0]} + 12'd1;
				o.tbl_ofs  = {saved_tbl[31:3], 3'b000};
				o.tbl_bar  = saved_tbl[2:0];
				o.pba_ofs  = {it.read_data[31:3], 3'b000};
				o.pba_bar  = it.read_data[2:0];
			end
			produced++;
			awaited_outputs.push_back(o);
		endfunction

		function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
			if (want === got)
				return 1'b1;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			return 1'b0;
		endfunction

		function void compare_output(out_item_t got);
			out_item_t want;
			bit        ok;
			if (awaited_outputs.size() == 0) begin
				$display("%0t: unexpected output, actual 0x%0h", $time, got);
				errors++;
				return;
			end
			want = awaited_outputs.pop_front();
			ok = 1'b1;
			ok &= field_ok("out_kind", 32'(want.out_kind), 32'(got.out_kind));
			ok &= field_ok("config_address", 32'(want.config_address),
				32'(got.config_address));
			ok &= field_ok("found",    32'(want.found),    32'(got.found));
			ok &= field_ok("cap_ofs",  32'(want.cap_ofs),  32'(got.cap_ofs));
			ok &= field_ok("msg_ctrl", 32'(want.msg_ctrl), 32'(got.msg_ctrl));
			ok &= field_ok("tbl_len",  32'(want.tbl_len),  32'(got.tbl_len));
			ok &= field_ok("tbl_ofs",  want.tbl_ofs,       got.tbl_ofs);
			ok &= field_ok("tbl_bar",  32'(want.tbl_bar),  32'(got.tbl_bar));
			ok &= field_ok("pba_ofs",  want.pba_ofs,       got.pba_ofs);
			ok &= field_ok("pba_bar",  32'(want.pba_bar),  32'(got.pba_bar));
			if (!ok)
				errors++;
		endfunction

		function int unsigned pending();
			return awaited_outputs.size();
		endfunction
	endclass

	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_RHYTHM,
		RX_STARVED
	} rx_mode_t;

	localparam int unsigned RANDOM_ITEMS = 950;
	localparam int unsigned HOLD_AFTER   = 300;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n;

	msixw_in_if  walk_ch ();
	msixw_out_if result_ch ();

	walk_tracker tracker = new();

	// set per walk: a chain with no msi-x id and no end, so the header limit is hit
	bit long_chain;

	msix_capability_walker i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.walk   (walk_ch),
		.result (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous ceiling on the whole run
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic in_item_t dir_item(logic kind, logic [7:0] bus, logic [4:0] slot,
			logic [2:0] func, logic [31:0] data);
		in_item_t it;
		it.kind      = kind;
		it.bus       = bus;
		it.slot      = slot;
		it.func      = func;
		it.read_data = data;
		return it;
	endfunction

	// builds the next request from where the mirrored walk stands: mostly the
	// answer the walker is waiting for, with random content, sometimes noise
	function automatic in_item_t next_stimulus();
		in_item_t it;
		it.kind      = KIND_DATA;
		it.bus       = 8'($urandom);
		it.slot      = 5'($urandom);
		it.func      = 3'($urandom);
		it.read_data = $urandom;
		// noise: a start or a data item, whatever the walk phase
		if ($urandom_range(0, 19) == 0) begin
			it.kind = ($urandom_range(0, 1) != 0) ? KIND_START : KIND_DATA;
			return it;
		end
		case (tracker.phase)
			PH_IDLE: begin
				it.kind    = KIND_START;
				long_chain = ($urandom_range(0, 9) == 0);
			end
			PH_STATUS: begin
				it.read_data[CAP_LIST_BIT] = ($urandom_range(0, 7) != 0);
			end
			PH_PTR: begin
				if (!long_chain && $urandom_range(0, 9) == 0)
					it.read_data[7:0] = 8'h00;
				else if (it.read_data[7:0] == 8'h00)
					it.read_data[7:0] = 8'h40;
			end
			PH_HEADER: begin
				if (!long_chain && $urandom_range(0, 3) == 0)
					it.read_data[7:0] = CAP_ID_MSIX;
				else if (it.read_data[7:0] == CAP_ID_MSIX)
					it.read_data[7:0] = 8'h05;
				if (!long_chain && $urandom_range(0, 9) == 0)
					it.read_data[15:8] = 8'h00;
				else if (it.read_data[15:8] == 8'h00)
					it.read_data[15:8] = 8'h80;
			end
			default: ; // table and pba dwords stay fully random
		endcase
		return it;
	endfunction

	// offers one request and holds it until the walker takes it
	task automatic send_item(input in_item_t it);
		walk_ch.valid   <= 1'b1;
		walk_ch.payload <= it;
		do
			@(posedge clk);
		while (walk_ch.ready !== 1'b1);
		tracker.accept_item(it);
	endtask

	// every accepted output is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
			tracker.compare_output(result_ch.payload);
	end

	// receiver side: stall patterns of its own, plus one long hold-off so
	// the walker backs up and stalls its input while the sender keeps offering
	initial begin : receiver
		rx_mode_t    mode;
		int unsigned span;
		int unsigned k;
		bit          held;
		held = 1'b0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(16, 160);
			for (k = 0; k < span; k++) begin
				@(posedge clk);
				if (!held && tracker.accepted >= HOLD_AFTER) begin
					held = 1'b1;
					result_ch.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				case (mode)
					RX_ALWAYS:  result_ch.ready <= 1'b1;
					RX_COIN:    result_ch.ready <= ($urandom_range(0, 1) != 0);
					RX_RHYTHM:  result_ch.ready <= ((k % 4) != 0);
					default:    result_ch.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// sender side: reset, directed walks, then random walks in bursts
	initial begin : sender
		int unsigned burst_left;
		int unsigned gap;
		int unsigned target;
		arst_n = 1'b0;
		long_chain = 1'b0;
		walk_ch.valid   <= 1'b0;
		walk_ch.payload <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// data while idle is dropped
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'hFFFF_FFFF));
		// capability list bit clear, all-ones target
		send_item(dir_item(KIND_START, 8'hFF, 5'h1F, 3'h7, 32'h0000_0000));
		send_item(dir_item(KIND_DATA,  8'hFF, 5'h1F, 3'h7, 32'h0000_0000));
		// zero first pointer, all-zero target
		send_item(dir_item(KIND_START, 8'h00, 5'h00, 3'h0, 32'hFFFF_FFFF));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'hFFFF_FFFF));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'hFFFF_FF00));
		// start while busy, then msi-x at 0xff so table and pba offsets wrap
		send_item(dir_item(KIND_START, 8'hAA, 5'h15, 3'h5, 32'h0000_0000));
		send_item(dir_item(KIND_START, 8'h55, 5'h0A, 3'h2, 32'hFFFF_FFFF));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'h0010_0000));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'h0000_00FF));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'hFFFF_0011));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'hFFFF_FFFF));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'hFFFF_FFFF));
		// unaligned pointer, header with zero next pointer
		send_item(dir_item(KIND_START, 8'h12, 5'h03, 3'h1, 32'h0000_0000));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'h0010_0000));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'h0000_0041));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'h0000_0005));
		// msi-x at 0xfc, table request wraps to 0x00, all-zero control and dwords
		send_item(dir_item(KIND_START, 8'h01, 5'h01, 3'h1, 32'h0000_0000));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'h0010_0000));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'h0000_00FC));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'h0000_0011));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'h0000_0000));
		send_item(dir_item(KIND_DATA,  8'h00, 5'h00, 3'h0, 32'h0000_0000));

		// random walks; dropped requests do not count towards the total
		target = tracker.produced + RANDOM_ITEMS;
		burst_left = 0;
		while (tracker.produced < target) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					walk_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			send_item(next_stimulus());
			burst_left--;
		end
		walk_ch.valid <= 1'b0;

		// drain, then a short quiet spell to catch stray outputs
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/msixw_pkg.sv
rtl/msixw_in_if.sv
rtl/msixw_out_if.sv
rtl/msix_capability_walker.sv
tb/sv/tb_top.sv
